// ===== sv/bcli_pkg.sv =====
package bcli_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int ENTRY_WIDTH = 32;
    localparam int NBR_CNT     = 4;
    localparam int ROW_AW  = $clog2(MAX_ROWS);
    localparam int COL_AW  = $clog2(MAX_COLS);
    localparam int ADDR_W  = ROW_AW + COL_AW;
    localparam int DEPTH   = MAX_ROWS * MAX_COLS;

    localparam int FRAC_LIMIT = 16;
    localparam int SIZE_W  = 7;
    localparam int FB_W    = 5;
    localparam int IDX_W   = 6;
    localparam int COORD_W = 32;
    localparam int OUT_W   = 34;

    // cubic datapath: row results need 38 bits, the column pass 43
    localparam int ACC_W  = 43;
    localparam int SUM_W  = 46;
    localparam int PROD_W = SUM_W + FRAC_LIMIT + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC = 2'd2;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 88;

    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [FRAC_LIMIT-1:0]    frac_t;
    typedef logic [FB_W-1:0]          fb_t;
    typedef logic [IDX_W-1:0]         idx_t;

    typedef struct packed {
        idx_t [NBR_CNT-1:0] ci;
        idx_t [NBR_CNT-1:0] ri;
        frac_t tx;
        frac_t ty;
        fb_t   fb;
    } meta_t;

    function automatic sum_t ext_sum(acc_t a);
        return sum_t'(a);
    endfunction

endpackage

// ===== sv/fixed_point_bicubic_lut_interp_unit.sv =====
// Bicubic (Catmull-Rom) lookup over a 64 x 64 table of signed 32-bit samples.
// tuser selects the item kind: 0 stores write_value at (write_row, write_col)
// and gives no result, 1 interpolates at (x_coord, y_coord) and gives one
// result with the value and the clamped neighbour indices. One item is taken
// every clock while the output is not stalled. The block is built as a 12-stage
// pipeline with these stages in order: input
// register, index clamp, the read of sixteen table copies (one per neighbour),
// four stages of row cubics (three multiply steps and a final add) and four of
// the column cubic, and the saturating output register. A query sees every write
// taken before it. Entries must be written before a query reads them. Configuration
// writes are always accepted and should only be issued while the block is idle.
module fixed_point_bicubic_lut_interp_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // x_coord, y_coord, write_row, write_col, write_value, zero pad
    input  logic [bcli_pkg::S_TDATA_W-1:0]     s_tdata,
    // mode
    input  logic                               s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // interp_value, col_index_0..3, row_index_0..3, zero pad
    output logic [bcli_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bcli_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bcli_pkg::SIZE_W-1:0]        cfg_data
);
    import bcli_pkg::*;

    localparam int NSTG = 12;
    localparam int ST_RAM  = 2;
    localparam int ST_ROW  = 3;
    localparam int ST_COL  = 7;
    localparam int ST_OUT  = 11;

    logic [SIZE_W-1:0] rows_reg, cols_reg;
    logic [FB_W-1:0]   frac_reg;

    logic [NSTG-1:0] valid_reg, en, vin;

    logic                      mode0_reg, mode1_reg;
    logic signed [COORD_W-1:0] x0_reg, y0_reg;
    logic [IDX_W-1:0]          wrow0_reg, wcol0_reg, wrow1_reg, wcol1_reg;
    logic [ENTRY_WIDTH-1:0]    wval0_reg, wval1_reg;

    meta_t meta_reg [1:NSTG-1];
    meta_t meta_next;

    logic [SIZE_W-1:0] rows_eff, cols_eff;
    fb_t               fb_eff;
    frac_t             fmask;

    logic [OUT_W-1:0]  out_val_reg;
    logic [OUT_W-1:0]  out_val_next;

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= SIZE_W'(MAX_ROWS);
            cols_reg <= SIZE_W'(MAX_COLS);
            frac_reg <= FB_W'(8);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ROWS: rows_reg <= cfg_data;
                CFG_COLS: cols_reg <= cfg_data;
                CFG_FRAC: frac_reg <= cfg_data[FB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (rows_reg == '0) rows_eff = SIZE_W'(1);
        else if (rows_reg > SIZE_W'(MAX_ROWS)) rows_eff = SIZE_W'(MAX_ROWS);
        else rows_eff = rows_reg;
        if (cols_reg == '0) cols_eff = SIZE_W'(1);
        else if (cols_reg > SIZE_W'(MAX_COLS)) cols_eff = SIZE_W'(MAX_COLS);
        else cols_eff = cols_reg;
        fb_eff = (frac_reg > FB_W'(FRAC_LIMIT)) ? FB_W'(FRAC_LIMIT) : frac_reg;
        fmask  = frac_t'((17'd1 << fb_eff) - 17'd1);
    end

    // stage handshake: a stage loads when it is empty or its item moves on
    always_comb begin
        en[NSTG-1] = !valid_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        vin[0] = s_tvalid;
        for (int k = 1; k < NSTG; k++) begin
            vin[k] = valid_reg[k-1];
        end
        // writes leave the pipe once they reach the table
        vin[ST_RAM] = valid_reg[ST_RAM-1] && (mode1_reg == MODE_QUERY);
    end

    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) valid_reg[k] <= vin[k];
            end
        end
    end

    // neighbour index calculation for one axis
    function automatic idx_t [NBR_CNT-1:0] axis_idx(
        logic signed [COORD_W-1:0] coord, logic [SIZE_W-1:0] sz, fb_t fb);
        logic [22:0] hi;
        logic [22:0] c;
        logic [SIZE_W-1:0] base;
        logic [7:0] tj, vj, lim;
        idx_t [NBR_CNT-1:0] r;
        hi = 23'(sz) << fb;
        if (coord < 0) c = '0;
        else if (coord > $signed({9'b0, hi})) c = hi;
        else c = coord[22:0];
        base = SIZE_W'(c >> fb);
        lim = 8'(sz) - 8'd1;
        for (int j = 0; j < NBR_CNT; j++) begin
            tj = 8'(base) + 8'(j);
            vj = (tj == 8'd0) ? 8'd0 : tj - 8'd1;
            r[j] = (vj > lim) ? lim[IDX_W-1:0] : vj[IDX_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        meta_next.ci = axis_idx(x0_reg, cols_eff, fb_eff);
        meta_next.ri = axis_idx(y0_reg, rows_eff, fb_eff);
        meta_next.tx = x0_reg[FRAC_LIMIT-1:0] & fmask;
        meta_next.ty = y0_reg[FRAC_LIMIT-1:0] & fmask;
        meta_next.fb = fb_eff;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            mode0_reg <= s_tuser;
            x0_reg    <= s_tdata[31:0];
            y0_reg    <= s_tdata[63:32];
            wrow0_reg <= s_tdata[69:64];
            wcol0_reg <= s_tdata[75:70];
            wval0_reg <= s_tdata[107:76];
        end
        if (en[1]) begin
            mode1_reg   <= mode0_reg;
            wrow1_reg   <= wrow0_reg;
            wcol1_reg   <= wcol0_reg;
            wval1_reg   <= wval0_reg;
            meta_reg[1] <= meta_next;
        end
        for (int k = 2; k < NSTG; k++) begin
            if (en[k]) meta_reg[k] <= meta_reg[k-1];
        end
        if (en[ST_OUT]) out_val_reg <= out_val_next;
    end

    // sixteen table copies, one per neighbour, all written together
    logic table_we;
    logic [ENTRY_WIDTH-1:0] rd_word [NBR_CNT][NBR_CNT];
    acc_t row_p [NBR_CNT][NBR_CNT];
    acc_t row_y [NBR_CNT];
    acc_t col_y;

    assign table_we = en[ST_RAM] && valid_reg[ST_RAM-1] && (mode1_reg == MODE_WRITE);

    for (genvar i = 0; i < NBR_CNT; i++) begin : g_row
        for (genvar j = 0; j < NBR_CNT; j++) begin : g_col
            bcli_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(DEPTH)) u_ram (
                .aclk    (aclk),
                .wr_en   (table_we),
                .wr_addr ({wrow1_reg[ROW_AW-1:0], wcol1_reg[COL_AW-1:0]}),
                .wr_data (wval1_reg),
                .rd_en   (en[ST_RAM]),
                .rd_addr ({meta_reg[1].ri[i][ROW_AW-1:0], meta_reg[1].ci[j][COL_AW-1:0]}),
                .rd_data (rd_word[i][j])
            );
            assign row_p[i][j] = acc_t'($signed(rd_word[i][j]));
        end

        bcli_cubic u_row (
            .aclk    (aclk),
            .step_en (en[ST_ROW+3:ST_ROW]),
            .p_in    (row_p[i]),
            .t_in    (meta_reg[ST_RAM].ty),
            .f_in    (meta_reg[ST_RAM].fb),
            .y_out   (row_y[i])
        );
    end

    bcli_cubic u_col (
        .aclk    (aclk),
        .step_en (en[ST_COL+3:ST_COL]),
        .p_in    (row_y),
        .t_in    (meta_reg[ST_COL-1].tx),
        .f_in    (meta_reg[ST_COL-1].fb),
        .y_out   (col_y)
    );

    // saturate to the result field
    always_comb begin
        if (col_y > acc_t'(35'sh1_FFFF_FFFF)) out_val_next = {1'b0, {(OUT_W-1){1'b1}}};
        else if (col_y < -acc_t'(35'sh2_0000_0000)) out_val_next = {1'b1, {(OUT_W-1){1'b0}}};
        else out_val_next = col_y[OUT_W-1:0];
    end

    assign m_tvalid = valid_reg[ST_OUT];
    assign m_tdata  = {6'b0,
                       meta_reg[ST_OUT].ri[3], meta_reg[ST_OUT].ri[2],
                       meta_reg[ST_OUT].ri[1], meta_reg[ST_OUT].ri[0],
                       meta_reg[ST_OUT].ci[3], meta_reg[ST_OUT].ci[2],
                       meta_reg[ST_OUT].ci[1], meta_reg[ST_OUT].ci[0],
                       out_val_reg};

endmodule

// ===== sv/bcli_ram.sv =====
module bcli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bcli_cubic.sv =====
module bcli_cubic (
    input  logic                aclk,
    input  logic [3:0]          step_en,
    input  bcli_pkg::acc_t      p_in [4],
    input  bcli_pkg::frac_t     t_in,
    input  bcli_pkg::fb_t       f_in,
    output bcli_pkg::acc_t      y_out
);
    import bcli_pkg::*;

    acc_t  p1_reg [4];
    acc_t  p2_reg [4];
    acc_t  p3_reg [4];
    prod_t m1_reg, m2_reg, m3_reg;
    frac_t t1_reg, t2_reg;
    fb_t   f1_reg, f2_reg, f3_reg;
    acc_t  y_reg;

    sum_t  s0, s1, s2, a0, a1, a2;
    prod_t m1_next, m2_next, m3_next;
    acc_t  y_next;

    always_comb begin
        s0 = sum_t'(3) * (ext_sum(p_in[1]) - ext_sum(p_in[2]))
             + ext_sum(p_in[3]) - ext_sum(p_in[0]);
        m1_next = s0 * $signed({1'b0, t_in});

        a0 = sum_t'(m1_reg >>> f1_reg);
        s1 = sum_t'(2) * ext_sum(p1_reg[0]) - sum_t'(5) * ext_sum(p1_reg[1])
             + sum_t'(4) * ext_sum(p1_reg[2]) - ext_sum(p1_reg[3]) + a0;
        m2_next = s1 * $signed({1'b0, t1_reg});

        a1 = sum_t'(m2_reg >>> f2_reg);
        s2 = ext_sum(p2_reg[2]) - ext_sum(p2_reg[0]) + a1;
        m3_next = s2 * $signed({1'b0, t2_reg});

        a2 = sum_t'(m3_reg >>> (f3_reg + fb_t'(1)));
        y_next = acc_t'(ext_sum(p3_reg[1]) + a2);
    end

    always_ff @(posedge aclk) begin
        if (step_en[0]) begin
            m1_reg <= m1_next;
            p1_reg <= p_in;
            t1_reg <= t_in;
            f1_reg <= f_in;
        end
        if (step_en[1]) begin
            m2_reg <= m2_next;
            p2_reg <= p1_reg;
            t2_reg <= t1_reg;
            f2_reg <= f1_reg;
        end
        if (step_en[2]) begin
            m3_reg <= m3_next;
            p3_reg <= p2_reg;
            f3_reg <= f2_reg;
        end
        if (step_en[3]) begin
            y_reg <= y_next;
        end
    end

    assign y_out = y_reg;

endmodule
